[rtl/tmcg_pkg.sv]
// ----------------------------------------------------------------------------
// tmcg_pkg
// Types and constants shared by the text-mode character generator.
// ----------------------------------------------------------------------------
package tmcg_pkg;

   localparam int CHAR_DEPTH  = 512;
   localparam int FONT_DEPTH  = 4096;
   localparam int CHAR_ADDR_W = 9;
   localparam int FONT_ADDR_W = 12;
   localparam int CELL_CALC_W = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [1:0] {
      ACT_CHAR_WRITE = 2'd0,
      ACT_FONT_WRITE = 2'd1,
      ACT_PIXEL_TICK = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   localparam logic [0:0] REG_DISPLAY_MODE = 1'b0;

   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] address;
      logic [7:0]  data;
   } req_word_type;

   typedef struct packed {
      logic       pixel_white;
      logic [7:0] pixel_x;
      logic [6:0] pixel_y;
      logic       frame_end;
   } rsp_word_type;

endpackage

[rtl/tmcg_raster.sv]
// ----------------------------------------------------------------------------
// tmcg_raster
// Raster position counter with end-of-frame flag and character cell index.
// ----------------------------------------------------------------------------
module tmcg_raster #(
   parameter int TEXT_COLUMNS = 32,
   parameter int TEXT_ROWS    = 16,
   localparam int FRAME_W     = TEXT_COLUMNS * 8,
   localparam int FRAME_H     = TEXT_ROWS * 8,
   localparam int X_W         = $clog2(FRAME_W),
   localparam int Y_W         = $clog2(FRAME_H)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   output logic [X_W-1:0]                   x,
   output logic [Y_W-1:0]                   y,
   output logic [tmcg_pkg::CHAR_ADDR_W-1:0] cell_index,
   output logic                             last
);

   logic [X_W-1:0]                   x_ff, x_in;
   logic [Y_W-1:0]                   y_ff, y_in;
   logic                             x_end, y_end;
   logic [tmcg_pkg::CELL_CALC_W-1:0] cell_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   always_comb begin
      x_end = (x_ff == X_W'(FRAME_W - 1));
      y_end = (y_ff == Y_W'(FRAME_H - 1));
      x_in  = x_ff;
      y_in  = y_ff;
      if (advance) begin
         if (x_end) begin
            x_in = '0;
            y_in = y_end ? '0 : y_ff + Y_W'(1);
         end else begin
            x_in = x_ff + X_W'(1);
         end
      end
   end

   always_comb begin
      cell_full = tmcg_pkg::CELL_CALC_W'(y_ff >> 3) * tmcg_pkg::CELL_CALC_W'(TEXT_COLUMNS)
                + tmcg_pkg::CELL_CALC_W'(x_ff >> 3);
   end

   assign x          = x_ff;
   assign y          = y_ff;
   assign cell_index = cell_full[tmcg_pkg::CHAR_ADDR_W-1:0];
   assign last       = x_end && y_end;

endmodule

[rtl/text_mode_character_generator_core.sv]
// ----------------------------------------------------------------------------
// text_mode_character_generator_core
// Text-mode pixel generator: character memory, 8x8 font store, raster scan.
// ----------------------------------------------------------------------------
// Input words (req_) carry an action: character memory write, font store write,
// pixel tick or no action. Writes produce no output word. Each pixel tick
// produces one output word (rsp_) with the pixel color, its raster position
// and an end-of-frame flag, then advances the raster.
// One input word is accepted per cycle unless the pipeline is full. A pixel
// tick is loaded into the character memory read register at its accepting
// edge, then moves through the font store read register and the output
// register to rsp_valid. Throughput is one word per cycle while rsp_ready
// stays high, set by the single read port of each memory.
// The display_mode register is written over the csr_ port at byte address 0
// and must only change while no word is in flight.
// Reset clears the raster to the top-left pixel, the mode register and the
// pipeline valids; memories keep their contents and are undefined until
// written. When rsp_ready is low the output word holds, and stages behind it
// keep filling until the pipeline is full, at which point req_ready drops.
// ----------------------------------------------------------------------------
module text_mode_character_generator_core #(
   parameter int TEXT_COLUMNS = 32,
   parameter int TEXT_ROWS    = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tmcg_pkg::req_word_type          req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tmcg_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tmcg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tmcg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tmcg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int X_W = $clog2(TEXT_COLUMNS * 8);
   localparam int Y_W = $clog2(TEXT_ROWS * 8);

   // configuration
   logic [1:0] mode_ff, mode_in;
   logic       csr_hit;

   // raster
   logic [X_W-1:0]                   ras_x;
   logic [Y_W-1:0]                   ras_y;
   logic [tmcg_pkg::CHAR_ADDR_W-1:0] ras_cell;
   logic                             ras_last;

   // memories
   logic [7:0] char_mem [tmcg_pkg::CHAR_DEPTH];
   logic [7:0] font_mem [tmcg_pkg::FONT_DEPTH];
   logic [7:0] char_rd_ff;
   logic [7:0] font_rd_ff;

   // handshake
   logic accept, tick_acc, char_wr, s1_load;
   logic en2, out_en;

   // stage 1
   logic                             s1_valid_ff, s1_valid_in;
   logic                             s1_tick_ff;
   logic [tmcg_pkg::FONT_ADDR_W-1:0] s1_addr_ff;
   logic [7:0]                       s1_data_ff;
   logic [X_W-1:0]                   s1_x_ff;
   logic [Y_W-1:0]                   s1_y_ff;
   logic                             s1_last_ff;
   logic [tmcg_pkg::FONT_ADDR_W-1:0] font_rd_addr;

   // stage 2
   logic           s2_valid_ff, s2_valid_in;
   logic [X_W-1:0] s2_x_ff;
   logic [Y_W-1:0] s2_y_ff;
   logic           s2_last_ff;
   logic           glyph_bit;

   // output
   logic                   rsp_valid_ff, rsp_valid_in;
   tmcg_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // ---- configuration port ----
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[tmcg_pkg::CSR_ADDR_W-1] == tmcg_pkg::REG_DISPLAY_MODE);

   always_comb begin
      mode_in = mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         mode_in = csr_pwdata[1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = tmcg_pkg::CSR_DATA_W'(mode_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // ---- handshake and stage enables ----
   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign en2       = s1_valid_ff && (!s1_tick_ff || !s2_valid_ff || out_en);
   assign req_ready = !s1_valid_ff || en2;
   assign accept    = req_valid && req_ready;
   assign tick_acc  = accept && (req_word.action == tmcg_pkg::ACT_PIXEL_TICK);
   assign char_wr   = accept && (req_word.action == tmcg_pkg::ACT_CHAR_WRITE);
   assign s1_load   = tick_acc ||
                      (accept && (req_word.action == tmcg_pkg::ACT_FONT_WRITE));

   tmcg_raster #(
      .TEXT_COLUMNS (TEXT_COLUMNS),
      .TEXT_ROWS    (TEXT_ROWS)
   ) u_raster (
      .clock      (clock),
      .reset      (reset),
      .advance    (tick_acc),
      .x          (ras_x),
      .y          (ras_y),
      .cell_index (ras_cell),
      .last       (ras_last)
   );

   // ---- character memory ----
   always_ff @(posedge clock) begin
      if (char_wr) begin
         char_mem[req_word.address[tmcg_pkg::CHAR_ADDR_W-1:0]] <= req_word.data;
      end
      if (tick_acc) begin
         char_rd_ff <= char_mem[ras_cell];
      end
   end

   // ---- stage 1 ----
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = s1_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_tick_ff <= tick_acc;
         s1_addr_ff <= req_word.address;
         s1_data_ff <= req_word.data;
         s1_x_ff    <= ras_x;
         s1_y_ff    <= ras_y;
         s1_last_ff <= ras_last;
      end
   end

   assign font_rd_addr = {mode_ff[0], char_rd_ff, s1_y_ff[2:0]};

   // ---- font store ----
   always_ff @(posedge clock) begin
      if (en2 && !s1_tick_ff) begin
         font_mem[s1_addr_ff] <= s1_data_ff;
      end
      if (en2 && s1_tick_ff) begin
         font_rd_ff <= font_mem[font_rd_addr];
      end
   end

   // ---- stage 2 ----
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (!s2_valid_ff || out_en) begin
         s2_valid_in = en2 && s1_tick_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && s1_tick_ff) begin
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ---- output register ----
   assign glyph_bit = font_rd_ff[3'd7 - s2_x_ff[2:0]];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_en) begin
         rsp_valid_in = s2_valid_ff;
         if (s2_valid_ff) begin
            rsp_word_in.pixel_white = mode_ff[1] ? glyph_bit : !glyph_bit;
            rsp_word_in.pixel_x     = 8'(s2_x_ff);
            rsp_word_in.pixel_y     = 7'(s2_y_ff);
            rsp_word_in.frame_end   = s2_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[tb/text_mode_character_generator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_character_generator_core_tb
// Self-checking bench for the text-mode character generator core.
// ----------------------------------------------------------------------------
// Words are queued by a stimulus process and sent by a clocked driver with
// random gaps; output stalls are random too. A shadow of the character
// memory, font store, raster and mode register predicts every pixel word,
// and the monitor compares each output word field by field. Ticks only read
// cells and glyph rows that were written first. The run ends with a stretch
// of back-to-back ticks and no output stalls.
// ----------------------------------------------------------------------------
module text_mode_character_generator_core_tb;

   localparam int COLS        = 32;
   localparam int ROWS        = 16;
   localparam int FRAME_W     = COLS * 8;
   localparam int FRAME_H     = ROWS * 8;
   localparam int FRAME_PIX   = FRAME_W * FRAME_H;
   localparam int CYCLE_LIMIT = 1000000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   tmcg_pkg::req_word_type          req_word = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   tmcg_pkg::rsp_word_type          rsp_word;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [tmcg_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [tmcg_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [tmcg_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   text_mode_character_generator_core #(
      .TEXT_COLUMNS(COLS),
      .TEXT_ROWS   (ROWS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   tmcg_pkg::req_word_type pending_words[$];
   tmcg_pkg::rsp_word_type due_pixels[$];
   int                     fail_count = 0;
   int                     cycle_count = 0;
   bit                     word_taken = 1'b0;
   bit                     idle_on = 1'b0;
   int                     send_gap = 0;
   int                     stall_left = 0;

   // predictor state, updated on accepted words
   logic [7:0] char_copy [tmcg_pkg::CHAR_DEPTH];
   logic [7:0] font_copy [tmcg_pkg::FONT_DEPTH];
   int         scan_x = 0;
   int         scan_y = 0;
   logic [1:0] mode_copy = 2'd0;

   // stimulus-side view, updated as words are queued
   logic [7:0] gen_char [tmcg_pkg::CHAR_DEPTH];
   bit         char_known [tmcg_pkg::CHAR_DEPTH];
   bit         font_known [tmcg_pkg::FONT_DEPTH];
   int         gen_pos = 0;
   logic [1:0] gen_mode = 2'd0;
   int         word_count = 0;

   function automatic void raster_step(tmcg_pkg::req_word_type w);
      int                     cell_idx;
      logic [8:0]             code;
      logic [7:0]             row;
      logic                   lit;
      tmcg_pkg::rsp_word_type px;
      case (w.action)
         tmcg_pkg::ACT_CHAR_WRITE: char_copy[w.address[tmcg_pkg::CHAR_ADDR_W-1:0]] = w.data;
         tmcg_pkg::ACT_FONT_WRITE: font_copy[w.address] = w.data;
         tmcg_pkg::ACT_PIXEL_TICK: begin
            cell_idx = ((scan_y >> 3) * COLS + (scan_x >> 3)) % tmcg_pkg::CHAR_DEPTH;
            code = {mode_copy[0], char_copy[cell_idx]};
            row = font_copy[{code, scan_y[2:0]}];
            lit = row[3'd7 - scan_x[2:0]];
            px.pixel_white = mode_copy[1] ? lit : ~lit;
            px.pixel_x = scan_x[7:0];
            px.pixel_y = scan_y[6:0];
            px.frame_end = (scan_x == FRAME_W - 1) && (scan_y == FRAME_H - 1);
            due_pixels.push_back(px);
            if (scan_x + 1 >= FRAME_W) begin
               scan_x = 0;
               scan_y = (scan_y + 1 >= FRAME_H) ? 0 : scan_y + 1;
            end else begin
               scan_x = scan_x + 1;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void queue_word(tmcg_pkg::action_type act, logic [11:0] addr,
                                      logic [7:0] data);
      tmcg_pkg::req_word_type w;
      w.action = act;
      w.address = addr;
      w.data = data;
      pending_words.push_back(w);
      case (act)
         tmcg_pkg::ACT_CHAR_WRITE: begin
            gen_char[addr[tmcg_pkg::CHAR_ADDR_W-1:0]] = data;
            char_known[addr[tmcg_pkg::CHAR_ADDR_W-1:0]] = 1'b1;
         end
         tmcg_pkg::ACT_FONT_WRITE: font_known[addr] = 1'b1;
         tmcg_pkg::ACT_PIXEL_TICK: gen_pos = (gen_pos + 1) % FRAME_PIX;
         default: ;
      endcase
      if (act != tmcg_pkg::ACT_NONE)
         word_count++;
   endfunction

   // pixel tick, preceded by writes to any cell or glyph row it would read unwritten
   function automatic void queue_tick();
      int          gx;
      int          gy;
      int          cell_idx;
      logic [11:0] faddr;
      gx = gen_pos % FRAME_W;
      gy = gen_pos / FRAME_W;
      cell_idx = ((gy >> 3) * COLS + (gx >> 3)) % tmcg_pkg::CHAR_DEPTH;
      if (!char_known[cell_idx])
         queue_word(tmcg_pkg::ACT_CHAR_WRITE, {3'($urandom_range(0, 7)), 9'(cell_idx)},
                    8'($urandom));
      faddr = {gen_mode[0], gen_char[cell_idx], 3'(gy % 8)};
      if (!font_known[faddr])
         queue_word(tmcg_pkg::ACT_FONT_WRITE, faddr, 8'($urandom));
      queue_word(tmcg_pkg::ACT_PIXEL_TICK, 12'($urandom), 8'($urandom));
   endfunction

   function automatic void queue_random_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         queue_tick();
      else if (pick < 70)
         queue_word(tmcg_pkg::ACT_CHAR_WRITE, 12'($urandom), 8'($urandom));
      else if (pick < 88)
         queue_word(tmcg_pkg::ACT_FONT_WRITE, 12'($urandom), 8'($urandom));
      else
         queue_word(tmcg_pkg::ACT_NONE, 12'($urandom), 8'($urandom));
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic wait_idle();
      while (pending_words.size() != 0 || req_valid || due_pixels.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_display_mode(logic [1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {tmcg_pkg::REG_DISPLAY_MODE, 2'b00};
      csr_pwdata <= tmcg_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      mode_copy = value;
      gen_mode = value;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== tmcg_pkg::CSR_DATA_W'(value)) begin
         $error("display_mode mismatch: expected %0d actual %0d", value, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_mode_phase(logic [1:0] mode, int count, bit settle_midway);
      int start;
      bit settled;
      write_display_mode(mode);
      start = word_count;
      settled = 1'b0;
      while (word_count - start < count) begin
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (60) queue_random_word();
         while (pending_words.size() != 0)
            @(posedge clock);
         if (settle_midway && !settled && word_count - start >= count / 2) begin
            wait_idle();
            settled = 1'b1;
         end
      end
      wait_idle();
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || word_taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         word_taken = 1'b0;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : pixel_monitor
      tmcg_pkg::rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            raster_step(req_word);
            word_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (due_pixels.size() == 0) begin
               $error("unexpected output word %h", rsp_word);
               fail_count++;
            end else begin
               want = due_pixels.pop_front();
               check_field("pixel_white", want.pixel_white, rsp_word.pixel_white);
               check_field("pixel_x", want.pixel_x, rsp_word.pixel_x);
               check_field("pixel_y", want.pixel_y, rsp_word.pixel_y);
               check_field("frame_end", want.frame_end, rsp_word.frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_display_mode(2'd0);
      idle_on = 1'b1;
      queue_word(tmcg_pkg::ACT_CHAR_WRITE, 12'hE00, 8'h80);  // wraps to cell 0
      queue_word(tmcg_pkg::ACT_FONT_WRITE, 12'h400, 8'hA5);  // glyph 0x80, row 0
      repeat (8) queue_tick();                               // bits of one row, MSB first
      queue_word(tmcg_pkg::ACT_NONE, 12'hFFF, 8'hFF);
      queue_word(tmcg_pkg::ACT_FONT_WRITE, 12'hFFF, 8'hFF);
      queue_word(tmcg_pkg::ACT_FONT_WRITE, 12'h000, 8'h00);
      queue_word(tmcg_pkg::ACT_CHAR_WRITE, 12'h1FF, 8'hFF);
      queue_word(tmcg_pkg::ACT_CHAR_WRITE, 12'h001, 8'h00);
      queue_word(tmcg_pkg::ACT_NONE, 12'h000, 8'h00);
      repeat (8) queue_tick();
      wait_idle();

      run_mode_phase(2'd3, 450, 1'b0);
      run_mode_phase(2'd1, 450, 1'b1);
      run_mode_phase(2'd2, 450, 1'b0);

      // no idling from here: back-to-back ticks
      write_display_mode(2'd3);
      idle_on = 1'b0;
      send_gap = 0;
      stall_left = 0;
      repeat (150) queue_tick();
      wait_idle();

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
